// ===== hdl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// sme_pkg
// shared opcodes, status codes and the decode word of the stack machine
// ----------------------------------------------------------------------------
package sme_pkg;

  typedef enum logic [3:0] {
    OP_LDC = 4'd0,
    OP_LD  = 4'd1,
    OP_ST  = 4'd2,
    OP_ADD = 4'd3,
    OP_SUB = 4'd4,
    OP_CMP = 4'd5,
    OP_BR  = 4'd6,
    OP_JMP = 4'd7,
    OP_RET = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_STOP  = 3'd1,
    ST_UNDER = 3'd2,
    ST_OVER  = 3'd3,
    ST_ADDR  = 3'd4
  } status_t;

  // push and pop are already gated by an ok status
  typedef struct packed {
    status_t status;
    logic    push;
    logic    pop;
  } dec_t;

endpackage

// ===== hdl/sme_decode.sv =====
// ----------------------------------------------------------------------------
// sme_decode
// checks one instruction against the stack count and data address range
// ----------------------------------------------------------------------------
module sme_decode #(
  parameter int STACK_DEPTH = 256,
  parameter int MEM_WORDS   = 256,
  parameter int CW          = 9
) (
  input  logic [3:0]        func,
  input  logic signed [31:0] operand,
  input  logic [CW-1:0]     count,
  output sme_pkg::dec_t     dec
);

  logic [31:0] addr_u;
  logic        full;
  logic        has1;
  logic        has2;
  logic        addr_ok;

  assign addr_u  = operand;
  assign full    = (count == CW'(STACK_DEPTH));
  assign has1    = (count != '0);
  assign has2    = (count >= CW'(2));
  assign addr_ok = !addr_u[31] && (addr_u != 32'd0) && (addr_u < 32'(MEM_WORDS));

  always_comb begin
    dec.status = sme_pkg::ST_OK;
    dec.push   = 1'b0;
    dec.pop    = 1'b0;
    case (func)
      sme_pkg::OP_LDC: begin
        if (full) dec.status = sme_pkg::ST_OVER;
        else dec.push = 1'b1;
      end
      sme_pkg::OP_LD: begin
        if (full) dec.status = sme_pkg::ST_OVER;
        else if (!addr_ok) dec.status = sme_pkg::ST_ADDR;
        else dec.push = 1'b1;
      end
      sme_pkg::OP_ST: begin
        if (!addr_ok) dec.status = sme_pkg::ST_ADDR;
        else if (!has1) dec.status = sme_pkg::ST_UNDER;
        else dec.pop = 1'b1;
      end
      sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_CMP: begin
        if (!has2) dec.status = sme_pkg::ST_UNDER;
        else dec.pop = 1'b1;
      end
      sme_pkg::OP_BR: begin
        if (!has1) dec.status = sme_pkg::ST_UNDER;
      end
      sme_pkg::OP_JMP: begin
        dec.status = sme_pkg::ST_OK;
      end
      default: begin
        // ret and unused opcodes stop
        dec.status = sme_pkg::ST_STOP;
      end
    endcase
  end

endmodule

// ===== hdl/stack_machine_execute.sv =====
// ----------------------------------------------------------------------------
// stack_machine_execute
// execution unit of a word-wide stack machine, one decoded instruction a word
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with in_func and in_operand, one
//   decoded instruction per word
//   result channel: out_valid / out_stall with status, jump request, new top
//   of stack and stack depth, exactly one result word per instruction
//   throughput: one instruction per cycle while not stalled, set by the single
//   read-modify-write pass through the stack memory and the data memory
//   pipeline: decode and the memory reads happen before the edge that accepts
//   a word into the execute registers; execute then fills the output register,
//   which drives out_valid
//   reset: the stack empties at once; the data memory is then zeroed one word
//   a cycle, with in_stall held high until every word is cleared
//   a stalled output holds its word and freezes the whole pipe; after clearing,
//   the next word is taken whenever the output register is empty or drains
// ----------------------------------------------------------------------------
module stack_machine_execute #(
  parameter int STACK_DEPTH = 256,
  parameter int MEM_WORDS   = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_func,
  input  logic signed [31:0] in_operand,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic               out_jump_request,
  output logic signed [31:0] out_top_value,
  output logic [8:0]         out_stack_depth
);

  localparam int CW  = $clog2(STACK_DEPTH + 1);  // count, holds the depth itself
  localparam int SAW = $clog2(STACK_DEPTH);      // stack memory index
  localparam int MAW = $clog2(MEM_WORDS);        // data memory index
  localparam int DW  = (CW > 9) ? CW : 9;

  // memories: stack is write-through of the top, top and second also in regs
  logic [31:0] stk_mem [STACK_DEPTH];
  logic [31:0] dmem    [MEM_WORDS];

  // clearing pass
  logic           clearing_r;
  logic [MAW-1:0] clr_cnt_r;

  // handshake
  logic advance;
  logic in_accept;

  // decode stage
  sme_pkg::dec_t  dec_a;
  logic [CW-1:0]  count_a_r;
  logic [CW-1:0]  count_a_nxt;
  logic [CW-1:0]  third_addr;

  // execute stage
  logic               valid_b_r;
  logic [3:0]         func_b_r;
  logic [31:0]        operand_b_r;
  sme_pkg::dec_t      dec_b_r;
  logic [CW-1:0]      cnt_b_r;
  logic [31:0]        third_r;     // stack entry below the second
  logic [31:0]        ld_rd_r;
  logic               fwd_hit_r;   // ld read an address st was writing
  logic [31:0]        fwd_data_r;

  // top of stack and the word below it
  logic [31:0] tos_r;
  logic [31:0] tos_nxt;
  logic [31:0] nos_r;
  logic [31:0] nos_nxt;
  logic        jump_nxt;
  logic [31:0] alu_res;
  logic [31:0] ld_val;
  logic        stk_we;
  logic        st_we;
  logic [CW-1:0] top_idx;
  logic [DW-1:0] cnt_wide;

  // output register
  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic               out_jump_r;
  logic signed [31:0] out_top_r;
  logic [8:0]         out_depth_r;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = clearing_r || !advance;
  assign in_accept = in_valid && !in_stall;

  // ---------------- decode: checks, count, memory reads ----------------
  sme_decode #(
    .STACK_DEPTH(STACK_DEPTH),
    .MEM_WORDS  (MEM_WORDS),
    .CW         (CW)
  ) u_decode (
    .func   (in_func),
    .operand(in_operand),
    .count  (count_a_r),
    .dec    (dec_a)
  );

  always_comb begin
    count_a_nxt = count_a_r;
    if (dec_a.push) count_a_nxt = count_a_r + CW'(1);
    else if (dec_a.pop) count_a_nxt = count_a_r - CW'(1);
  end

  // third word from the top before this instruction; the word in execute
  // writes its new top two slots higher, so the two never collide
  assign third_addr = count_a_r - CW'(3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r <= '0;
    end else if (in_accept) begin
      count_a_r <= count_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else if (advance) begin
      valid_b_r <= in_accept;
      fwd_hit_r <= st_we && (operand_b_r[MAW-1:0] == in_operand[MAW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      func_b_r    <= in_func;
      operand_b_r <= in_operand;
      dec_b_r     <= dec_a;
      cnt_b_r     <= count_a_nxt;
      fwd_data_r  <= tos_r;
    end
  end

  // ---------------- execute: alu, top update, write back ----------------
  assign ld_val = fwd_hit_r ? fwd_data_r : ld_rd_r;

  always_comb begin
    case (func_b_r)
      sme_pkg::OP_ADD: alu_res = tos_r + nos_r;
      sme_pkg::OP_SUB: alu_res = tos_r - nos_r;
      default: begin
        // compare as signed words
        if ($signed(tos_r) < $signed(nos_r)) alu_res = 32'hFFFF_FFFF;
        else if ($signed(tos_r) > $signed(nos_r)) alu_res = 32'd1;
        else alu_res = 32'd0;
      end
    endcase
  end

  always_comb begin
    tos_nxt  = tos_r;
    nos_nxt  = nos_r;
    jump_nxt = 1'b0;
    case (func_b_r)
      sme_pkg::OP_LDC: begin
        if (dec_b_r.push) begin
          tos_nxt = operand_b_r;
          nos_nxt = tos_r;
        end
      end
      sme_pkg::OP_LD: begin
        if (dec_b_r.push) begin
          tos_nxt = ld_val;
          nos_nxt = tos_r;
        end
      end
      sme_pkg::OP_ST: begin
        if (dec_b_r.pop) begin
          tos_nxt = nos_r;
          nos_nxt = third_r;
        end
      end
      sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_CMP: begin
        if (dec_b_r.pop) begin
          tos_nxt = alu_res;
          nos_nxt = third_r;
        end
      end
      sme_pkg::OP_BR: begin
        if (dec_b_r.status == sme_pkg::ST_OK) jump_nxt = (tos_r != 32'd0);
      end
      sme_pkg::OP_JMP: begin
        jump_nxt = 1'b1;
      end
      default: begin
        jump_nxt = 1'b0;
      end
    endcase
  end

  // new top goes to the stack memory whenever it is a fresh value
  assign stk_we  = valid_b_r &&
                   (dec_b_r.push || (dec_b_r.pop && (func_b_r != sme_pkg::OP_ST)));
  assign st_we   = valid_b_r && dec_b_r.pop && (func_b_r == sme_pkg::OP_ST);
  assign top_idx = cnt_b_r - CW'(1);

  always_ff @(posedge clk) begin
    if (advance && valid_b_r) begin
      tos_r <= tos_nxt;
      nos_r <= nos_nxt;
    end
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (advance && stk_we) begin
      stk_mem[top_idx[SAW-1:0]] <= tos_nxt;
    end
    if (advance) begin
      third_r <= stk_mem[third_addr[SAW-1:0]];
    end
  end

  // data memory, zeroed by the clearing pass
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      dmem[clr_cnt_r] <= 32'd0;
    end else if (advance && st_we) begin
      dmem[operand_b_r[MAW-1:0]] <= tos_r;
    end
    if (advance) begin
      ld_rd_r <= dmem[in_operand[MAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + MAW'(1);
      if (clr_cnt_r == MAW'(MEM_WORDS - 1)) clearing_r <= 1'b0;
    end
  end

  // ---------------- output register ----------------
  assign cnt_wide = DW'(cnt_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= valid_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && valid_b_r) begin
      out_status_r <= dec_b_r.status;
      out_jump_r   <= jump_nxt;
      out_top_r    <= (cnt_b_r == '0) ? 32'sd0 : $signed(tos_nxt);
      out_depth_r  <= cnt_wide[8:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_jump_request = out_jump_r;
  assign out_top_value    = out_top_r;
  assign out_stack_depth  = out_depth_r;

  // ---------------- assertions ----------------
  // stack count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_a_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // an error or stop never asks for a jump
  a_err_no_jump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != sme_pkg::ST_OK) |-> !out_jump_r)
    else $error("jump request with error status");

  // nothing is in flight while the data memory is being cleared
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !valid_b_r && !out_valid_r)
    else $error("word in flight during clearing pass");

  // an accepted push moves the count up by exactly one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && dec_a.push |=> count_a_r == $past(count_a_r) + CW'(1))
    else $error("push did not advance the count");

endmodule
